[rtl/rfm_pkg.sv]
// shared constants, types and codes for the reciprocal frequency meter
// used by rfm_div, reciprocal_frequency_meter_unit and rfm_checker
package rfm_pkg;

  localparam int TIMER_W   = 16;
  localparam int COUNT_W   = 10;
  localparam int SUM_W     = 32;
  localparam int CLK_W     = 24;
  localparam int SCALE_W   = 14;
  localparam int TCOUNT_W  = COUNT_W + 1;
  localparam int DEN_W     = SUM_W + 1;
  localparam int SBASE_W   = CLK_W + SCALE_W;
  localparam int NUM_W     = SBASE_W + TCOUNT_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int FREQ_W    = 32;
  localparam int OUT_W     = 48;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;

  localparam logic [SCALE_W-1:0]  FREQ_SCALE     = SCALE_W'(10000);
  localparam logic [TIMER_W-1:0]  MIN_INTERVAL_RST = TIMER_W'(10000);
  localparam logic [COUNT_W-1:0]  BATCH_SIZE_RST = COUNT_W'(50);
  localparam logic [CLK_W-1:0]    CLOCK_BASE_RST = CLK_W'(1000032);
  localparam logic [SUM_W-1:0]    SUM_MAX        = '1;
  localparam logic [FREQ_W-1:0]   FREQ_MAX       = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_BASE   = CFG_IDX_W'(2);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_MUL1  = 7'b0000100,
    ST_MUL2  = 7'b0001000,
    ST_START = 7'b0010000,
    ST_WAIT  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/reciprocal_frequency_meter_unit.sv]
// reciprocal frequency meter: interval filter, batch sums and scaled division
// depends on rfm_pkg and rfm_div
// a capture that closes no batch holds the input only through the check state; one that
// closes a batch also passes the multiply, start, wait and done states, mostly the 49-step divider
// the input takes no new capture until the sequencer is back in idle, which takes
// longer while an earlier result waits in the output register
// reset (rst, synchronous): clears the running and previous sums and counts and the reference
// capture, drops a pending result, and loads the register defaults 10000 / 50 / 1000032
module reciprocal_frequency_meter_unit import rfm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // capture stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [TIMER_W-1:0]   s_tdata,   // [15:0] capture_value
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // [31:0] freq_x10000, [41:32] sample_count, zeros above
  // register write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  state_t state;

  // configuration registers
  logic [TIMER_W-1:0] min_interval;
  logic [COUNT_W-1:0] batch_size;
  logic [CLK_W-1:0]   clock_base;

  // measurement state
  logic [TIMER_W-1:0] reference_capture;
  logic [SUM_W-1:0]   running_sum;
  logic [COUNT_W-1:0] running_count;
  logic [SUM_W-1:0]   previous_sum;
  logic [COUNT_W-1:0] previous_count;
  logic               have_previous;

  // working registers of one batch-closing transaction
  logic [TIMER_W-1:0]  capture;
  logic [SUM_W-1:0]    cur_sum;
  logic [COUNT_W-1:0]  cur_count;
  logic [DEN_W-1:0]    tot_sum;
  logic [TCOUNT_W-1:0] tot_count;
  logic [SBASE_W-1:0]  scaled_base;
  logic [NUM_W-1:0]    numerator;

  // output register
  logic [FREQ_W-1:0]  freq_x10000;
  logic [COUNT_W-1:0] sample_count;

  // interval path
  logic [TIMER_W-1:0] diff;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;
  logic [COUNT_W-1:0] count_inc;
  logic               keep;
  logic               close;

  // divider
  div_ctl_t         div_ctl;
  div_stat_t        div_stat;
  logic [NUM_W-1:0] quotient;
  logic             out_free;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign m_tdata   = {{(OUT_W - FREQ_W - COUNT_W){1'b0}}, sample_count, freq_x10000};

  // interval modulo the timer range, saturating sum, wrapping count
  assign diff      = capture - reference_capture;
  assign keep      = diff >= min_interval;
  assign sum_wide  = {1'b0, running_sum} + {{(SUM_W + 1 - TIMER_W){1'b0}}, diff};
  assign sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign count_inc = running_count + 1'b1;
  assign close     = count_inc >= batch_size;

  assign div_ctl.start = (state == ST_START);

  rfm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (numerator),
    .divisor  (tot_sum),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= MIN_INTERVAL_RST;
      batch_size   <= BATCH_SIZE_RST;
      clock_base   <= CLOCK_BASE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_INTERVAL: min_interval <= cfg_data[TIMER_W-1:0];
        REG_BATCH_SIZE:   batch_size   <= cfg_data[COUNT_W-1:0];
        REG_CLOCK_BASE:   clock_base   <= cfg_data[CLK_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and measurement state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      reference_capture <= '0;
      running_sum       <= '0;
      running_count     <= '0;
      previous_sum      <= '0;
      previous_count    <= '0;
      have_previous     <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          // a short interval leaves everything as it was
          if (keep) begin
            reference_capture <= capture;
            if (close) begin
              running_sum   <= '0;
              running_count <= '0;
              state         <= ST_MUL1;
            end else begin
              running_sum   <= sum_sat;
              running_count <= count_inc;
              state         <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MUL1: begin
          // the first batch stands in for its own predecessor
          have_previous  <= 1'b1;
          previous_sum   <= cur_sum;
          previous_count <= cur_count;
          state          <= ST_MUL2;
        end
        ST_MUL2:  state <= ST_START;
        ST_START: state <= ST_WAIT;
        ST_WAIT: begin
          if (div_stat.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // a finished batch fills the output register, a transaction empties it
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      capture <= s_tdata;
    end
    if (state == ST_CHECK) begin
      cur_sum   <= sum_sat;
      cur_count <= count_inc;
    end
    if (state == ST_MUL1) begin
      if (have_previous) begin
        tot_sum   <= {1'b0, previous_sum} + {1'b0, cur_sum};
        tot_count <= {1'b0, previous_count} + {1'b0, cur_count};
      end else begin
        tot_sum   <= {cur_sum, 1'b0};
        tot_count <= {cur_count, 1'b0};
      end
      scaled_base <= SBASE_W'(clock_base) * SBASE_W'(FREQ_SCALE);
    end
    if (state == ST_MUL2) begin
      numerator <= NUM_W'(scaled_base) * NUM_W'(tot_count);
    end
    // a zero divisor yields an all-ones quotient, which saturates as well
    if (state == ST_DONE && out_free) begin
      freq_x10000  <= (quotient[NUM_W-1:FREQ_W] != '0) ? FREQ_MAX
                                                        : quotient[FREQ_W-1:0];
      sample_count <= cur_count;
    end
  end

endmodule

[rtl/rfm_div.sv]
// restoring divider, one quotient bit per cycle
// depends on rfm_pkg
module rfm_div import rfm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [NUM_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NUM_W-1:0]     dvd;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic [DEN_W:0]       trial;
  logic                 fits;

  assign trial = {rem, dvd[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(NUM_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  // quotient bits shift into the dividend register from the bottom
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      dvd <= {dvd[NUM_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = busy && (cnt == '0);
  assign quotient  = dvd;

endmodule

[rtl/rfm_checker.sv]
// port-level checks for the reciprocal frequency meter, bound to the top level
// depends on rfm_pkg and reciprocal_frequency_meter_unit
module rfm_checker import rfm_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OUT_W-1:0]     m_tdata
);

  // no result right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a closed batch holds at least one interval
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[FREQ_W+COUNT_W-1:FREQ_W] != '0)
    else $error("result with zero sample count");

  // a pending result stays until taken
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped before transaction");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind reciprocal_frequency_meter_unit rfm_checker u_rfm_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// testbench for reciprocal_frequency_meter_unit: directed table then random capture phases
// depends on rfm_pkg and the meter rtl; predicts every batch result and checks it in order
module tb_top;
  import rfm_pkg::*;

  localparam int RANDOM_ITEMS  = 1700;    // accepted captures in the random part
  localparam int QUIET_ITEMS   = 200;     // last stretch with no idling on either side
  localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 80;      // lets a batch-closing capture finish
  localparam int DRAIN_CYCLES  = 100;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int DIR_ROWS      = 27;
  localparam int MAX_REPORTS   = 10;

  localparam logic [63:0] FREQ_MULT = 64'd10000;

  // index with no register behind it, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(3);

  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [COUNT_W-1:0] count;
  } meas_t;

  typedef enum logic {ROW_CAP, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;      // register index, cfg rows only
    logic [CFG_DAT_W-1:0]   value;    // register data or capture value
    logic                   typed;    // expected result typed in below
    meas_t                  want;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  logic                 s_tvalid;
  logic                 s_tready;
  logic [TIMER_W-1:0]   s_tdata;    // [15:0] capture_value
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;    // [31:0] freq_x10000, [41:32] sample_count, zeros above
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // predictor copy of the registers
  logic [TIMER_W-1:0] min_ticks;
  logic [COUNT_W-1:0] batch_len;
  logic [CLK_W-1:0]   tick_rate;

  // predictor copy of the batch state
  logic [TIMER_W-1:0] anchor_cap;
  logic [SUM_W-1:0]   acc_sum;
  logic [COUNT_W-1:0] acc_cnt;
  logic [SUM_W-1:0]   last_sum;
  logic [COUNT_W-1:0] last_cnt;
  logic               have_last;

  meas_t pending_meas[$];   // batch results still owed by the block
  int    mismatch_count = 0;
  int    cycle_count = 0;

  bit no_idle  = 1'b0;      // set for the closing stretch
  bit flood    = 1'b0;      // sender offers back to back
  bit hold_req = 1'b0;      // asks the receiver for a long hold-off

  reciprocal_frequency_meter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // directed rows, in order; comments say what each one exercises
  row_t dir_rows [DIR_ROWS] = '{
    '{ROW_CAP, '0, 24'd0,      1'b0, '0},   // zero interval at reset, ignored
    '{ROW_CAP, '0, 24'd9999,   1'b0, '0},   // one tick short of the default minimum
    '{ROW_CFG, REG_BATCH_SIZE, 24'd1, 1'b0, '0},
    // first batch stands in for its predecessor: freq equals the tick rate
    '{ROW_CAP, '0, 24'd10000,  1'b1, '{32'd1000032, 10'd1}},
    '{ROW_CAP, '0, 24'd30000,  1'b0, '0},
    '{ROW_CAP, '0, 24'd65535,  1'b0, '0},   // capture all ones
    '{ROW_CAP, '0, 24'd20000,  1'b0, '0},   // timer wrapped between edges
    '{ROW_CFG, REG_MIN_INTERVAL, 24'd0, 1'b0, '0},
    '{ROW_CAP, '0, 24'd20000,  1'b0, '0},   // zero-length interval accepted
    // both batches sum to zero, result saturates
    '{ROW_CAP, '0, 24'd20000,  1'b1, '{32'hFFFF_FFFF, 10'd1}},
    '{ROW_CFG, REG_CLOCK_BASE,   24'hFF_FFFF, 1'b0, '0},
    '{ROW_CFG, REG_MIN_INTERVAL, 24'd1,       1'b0, '0},
    // tiny total sum with the top tick rate, quotient past 32 bits
    '{ROW_CAP, '0, 24'd20001,  1'b1, '{32'hFFFF_FFFF, 10'd1}},
    '{ROW_CFG, REG_MIN_INTERVAL, 24'h00_FFFF, 1'b0, '0},
    '{ROW_CAP, '0, 24'd19999,  1'b0, '0},   // longest interval that is still short
    '{ROW_CAP, '0, 24'd20000,  1'b0, '0},   // longest possible interval
    '{ROW_CFG, REG_BATCH_SIZE,   24'd0,       1'b0, '0},
    '{ROW_CAP, '0, 24'd19999,  1'b0, '0},   // zero batch size closes at once
    '{ROW_CFG, REG_UNMAPPED,     24'hFF_FFFF, 1'b0, '0},
    '{ROW_CFG, REG_CLOCK_BASE,   24'd1,       1'b0, '0},
    '{ROW_CFG, REG_MIN_INTERVAL, 24'hFF_0000, 1'b0, '0},  // upper bits dropped, min 0
    '{ROW_CFG, REG_BATCH_SIZE,   24'hFF_FFFF, 1'b0, '0},  // batch of 1023
    '{ROW_CAP, '0, 24'd0,      1'b0, '0},
    '{ROW_CAP, '0, 24'd65535,  1'b0, '0},
    '{ROW_CAP, '0, 24'd65535,  1'b0, '0},
    '{ROW_CFG, REG_BATCH_SIZE,   24'd2,       1'b0, '0},  // lowered mid-batch
    '{ROW_CAP, '0, 24'd12345,  1'b0, '0}    // closes the batch of four
  };

  // one capture through the meter; returns 1 when it closes a batch
  function automatic bit measure_capture(input logic [TIMER_W-1:0] cap, output bit taken,
                                         output meas_t res);
    logic [TIMER_W-1:0] period_ticks;
    logic [SUM_W:0]     sum_ext;
    logic [SUM_W-1:0]   cur_sum;
    logic [COUNT_W-1:0] cur_cnt;
    logic [SUM_W:0]     tot_sum;
    logic [COUNT_W:0]   tot_cnt;
    logic [63:0]        scaled;
    logic [63:0]        quo;
    res = '0;
    period_ticks = cap - anchor_cap;   // wraps modulo the timer width
    taken = (period_ticks >= min_ticks);
    if (!taken) return 1'b0;
    anchor_cap = cap;
    sum_ext = {1'b0, acc_sum} + period_ticks;
    acc_sum = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    acc_cnt = acc_cnt + 1'b1;
    if (acc_cnt < batch_len) return 1'b0;
    cur_sum = acc_sum;
    cur_cnt = acc_cnt;
    acc_sum = '0;
    acc_cnt = '0;
    // very first batch doubles as its own predecessor
    if (!have_last) begin
      last_sum = cur_sum;
      last_cnt = cur_cnt;
      have_last = 1'b1;
    end
    tot_sum = {1'b0, last_sum} + cur_sum;
    tot_cnt = {1'b0, last_cnt} + cur_cnt;
    scaled = 64'(tick_rate) * FREQ_MULT * 64'(tot_cnt);
    if (tot_sum == '0) begin
      res.freq = {FREQ_W{1'b1}};
    end else begin
      quo = scaled / 64'(tot_sum);
      res.freq = (quo > 64'hFFFF_FFFF) ? {FREQ_W{1'b1}} : quo[FREQ_W-1:0];
    end
    res.count = cur_cnt;
    last_sum = cur_sum;
    last_cnt = cur_cnt;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] seen);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, seen);
  endtask

  // wait for every owed result, then let a possible batch close finish
  task automatic wait_idle();
    while (pending_meas.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write of a group
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MIN_INTERVAL: min_ticks = data[TIMER_W-1:0];
      REG_BATCH_SIZE:   batch_len = data[COUNT_W-1:0];
      REG_CLOCK_BASE:   tick_rate = data[CLK_W-1:0];
      default: ;
    endcase
  endtask

  // offer one capture; on the transaction predict it and maybe idle afterwards
  task automatic send_capture(input logic [TIMER_W-1:0] cap, input bit use_typed,
                              input meas_t typed_meas, output bit taken);
    meas_t got;
    bit    closes;
    s_tvalid <= 1'b1;
    s_tdata  <= cap;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    closes = measure_capture(cap, taken, got);
    if (use_typed)
      pending_meas.push_back(typed_meas);
    else if (closes)
      pending_meas.push_back(got);
    if (!no_idle && !flood && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // stimulus: reset, directed table, random phases, drain
  initial begin
    bit                 taken;
    int                 accepted_total;
    int                 phase;
    int                 phase_len;
    int                 got;
    int                 roll;
    int                 span;
    int                 hi;
    logic [COUNT_W-1:0] next_batch;
    logic [TIMER_W-1:0] next_min;
    logic [CLK_W-1:0]   next_rate;
    logic [TIMER_W-1:0] cap;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    min_ticks  = MIN_INTERVAL_RST;
    batch_len  = BATCH_SIZE_RST;
    tick_rate  = CLOCK_BASE_RST;
    anchor_cap = '0;
    acc_sum    = '0;
    acc_cnt    = '0;
    last_sum   = '0;
    last_cnt   = '0;
    have_last  = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table; register groups are written only with the meter idle
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        if (r == 0 || dir_rows[r-1].kind != ROW_CFG) begin
          s_tvalid <= 1'b0;
          wait_idle();
        end
        write_reg(dir_rows[r].idx, dir_rows[r].value);
        if (r + 1 == DIR_ROWS || dir_rows[r+1].kind != ROW_CFG)
          cfg_valid <= 1'b0;
      end else begin
        send_capture(dir_rows[r].value[TIMER_W-1:0], dir_rows[r].typed, dir_rows[r].want,
                     taken);
      end
    end

    // random phases, each with its own register setting
    accepted_total = 0;
    phase = 0;
    while (accepted_total < RANDOM_ITEMS) begin
      s_tvalid <= 1'b0;
      wait_idle();

      roll = $urandom_range(0, 99);
      if (roll < 70)      next_batch = COUNT_W'($urandom_range(1, 8));
      else if (roll < 88) next_batch = COUNT_W'($urandom_range(9, 100));
      else if (roll < 94) next_batch = '0;
      else                next_batch = '1;

      roll = $urandom_range(0, 99);
      if (roll < 25)      next_min = TIMER_W'($urandom_range(0, 64));
      else if (roll < 60) next_min = TIMER_W'($urandom_range(1000, 20000));
      else if (roll < 85) next_min = TIMER_W'($urandom_range(20000, 65535));
      else if (roll < 93) next_min = '0;
      else                next_min = '1;

      roll = $urandom_range(0, 99);
      if (roll < 3)       next_rate = '0;
      else if (roll < 12) next_rate = CLK_W'(1);
      else if (roll < 22) next_rate = '1;
      else                next_rate = CLK_W'($urandom_range(1, 24'hFF_FFFF));

      phase_len = $urandom_range(30, 150);

      // second phase: back-to-back offers while the receiver holds off
      if (phase == 1) begin
        next_batch = COUNT_W'(1);
        next_min   = TIMER_W'($urandom_range(0, 64));
        phase_len  = 150;
      end

      write_reg(REG_MIN_INTERVAL, {8'($urandom), next_min});
      write_reg(REG_BATCH_SIZE, {14'($urandom), next_batch});
      write_reg(REG_CLOCK_BASE, next_rate);
      cfg_valid <= 1'b0;

      roll = $urandom_range(0, 99);
      span = (roll < 40) ? 16 : (roll < 75) ? 2000 : 65535;
      flood = (phase == 1);
      hold_req = (phase == 1);

      // once the closing stretch begins the phase runs on to the end
      got = 0;
      while ((got < phase_len || no_idle) && accepted_total < RANDOM_ITEMS) begin
        no_idle = (accepted_total >= RANDOM_ITEMS - QUIET_ITEMS);
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // noise: any timer value
          cap = TIMER_W'($urandom);
        end else if (roll < 14 && min_ticks != '0) begin
          // glitch shorter than the minimum
          cap = anchor_cap + TIMER_W'($urandom_range(0, int'(min_ticks) - 1));
        end else begin
          hi = int'(min_ticks) + span;
          if (hi > 65535) hi = 65535;
          cap = anchor_cap + TIMER_W'($urandom_range(int'(min_ticks), hi));
        end
        send_capture(cap, 1'b0, '0, taken);
        if (taken) begin
          got++;
          accepted_total++;
        end
      end
      flood = 1'b0;
      phase++;
    end

    s_tvalid <= 1'b0;
    while (pending_meas.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // every result transaction is matched against the oldest owed result
  always @(posedge clk) begin
    meas_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_meas.size() == 0) begin
        report_mismatch("result with nothing pending", '0, 64'(m_tdata));
      end else begin
        want = pending_meas.pop_front();
        if (m_tdata[FREQ_W-1:0] !== want.freq)
          report_mismatch("freq_x10000", 64'(want.freq), 64'(m_tdata[FREQ_W-1:0]));
        if (m_tdata[FREQ_W +: COUNT_W] !== want.count)
          report_mismatch("sample_count", 64'(want.count), 64'(m_tdata[FREQ_W +: COUNT_W]));
        if (m_tdata[OUT_W-1:FREQ_W+COUNT_W] !== '0)
          report_mismatch("tdata padding", '0, 64'(m_tdata[OUT_W-1:FREQ_W+COUNT_W]));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
